>>> rtl/keyframe_position_lerp_assert.svh
// assertion macros for the keyframe position lerp block
// used by files that need clocked checks on clk with reset arst_n
`ifndef KEYFRAME_POSITION_LERP_ASSERT_SVH
`define KEYFRAME_POSITION_LERP_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define KPL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define KPL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/kpl_pkg.sv
// shared constants, key and position types for the keyframe position lerp block
// no dependencies
`timescale 1ns / 1ps

package kpl_pkg;

	localparam int MAX_KEYS = 64;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int FRAME_W  = 16;
	localparam int POS_W    = 32;
	localparam int FRAC_W   = 16;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] CFG_DEFAULT_X = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_Y = 2'd1;
	localparam logic [1:0] CFG_DEFAULT_Z = 2'd2;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic [FRAME_W-1:0]      frame;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} key_t;

	function automatic pos_t key_pos(input key_t k);
		pos_t p;
		p.x = k.x;
		p.y = k.y;
		p.z = k.z;
		return p;
	endfunction

endpackage

>>> rtl/kpl_key_ram.sv
// key storage: one write port, one registered read port
// depends on kpl_pkg for key_t and the track depth
`timescale 1ns / 1ps

module kpl_key_ram import kpl_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  key_t             wdata,
	input  logic [IDX_W-1:0] raddr,
	output key_t             rdata
);

	key_t mem [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/kpl_lerp_unit.sv
// shared interpolation unit: serial fraction divider, then per-axis subtract,
// multiply and add on one datapath; depends on kpl_pkg
`timescale 1ns / 1ps

module kpl_lerp_unit import kpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [FRAME_W-1:0] qframe,
	input  key_t               lo,
	input  key_t               hi,
	output logic               done,
	output pos_t               pos
);

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_DIV  = 5'b00010,
		L_SUB  = 5'b00100,
		L_MUL  = 5'b01000,
		L_ADD  = 5'b10000
	} lstate_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	localparam int STEP_W = $clog2(FRAC_W);
	localparam int PROD_W = POS_W + 1 + FRAC_W + 1;

	lstate_t                  st_q;
	axis_t                    axis_q;
	logic [STEP_W-1:0]        cnt_q;
	logic                     done_q;
	logic [FRAME_W-1:0]       rem_q;
	logic [FRAME_W-1:0]       den_q;
	logic [FRAC_W-1:0]        t_q;
	logic signed [POS_W:0]    diff_q;
	logic signed [PROD_W-1:0] prod_q;
	pos_t                     res_q;

	logic signed [POS_W-1:0] a_sel;
	logic signed [POS_W-1:0] b_sel;
	logic [FRAME_W:0]        r2;
	logic [FRAME_W:0]        r2_sub;
	logic                    ge;
	logic signed [POS_W-1:0] sum;

	always_comb begin
		case (axis_q)
			AX_X: begin
				a_sel = lo.x;
				b_sel = hi.x;
			end
			AX_Y: begin
				a_sel = lo.y;
				b_sel = hi.y;
			end
			AX_Z: begin
				a_sel = lo.z;
				b_sel = hi.z;
			end
			default: begin
				a_sel = lo.x;
				b_sel = hi.x;
			end
		endcase
	end

	assign r2     = {rem_q, 1'b0};
	assign r2_sub = r2 - {1'b0, den_q};
	assign ge     = r2 >= {1'b0, den_q};
	// floor of the product over 2^16 is an arithmetic shift
	assign sum    = a_sel + prod_q[FRAC_W+POS_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			axis_q <= AX_X;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (start) begin
						st_q  <= L_DIV;
						cnt_q <= '0;
					end
				end
				L_DIV: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(FRAC_W - 1)) begin
						st_q   <= L_SUB;
						axis_q <= AX_X;
					end
				end
				L_SUB: st_q <= L_MUL;
				L_MUL: st_q <= L_ADD;
				L_ADD: begin
					case (axis_q)
						AX_X: begin
							axis_q <= AX_Y;
							st_q   <= L_SUB;
						end
						AX_Y: begin
							axis_q <= AX_Z;
							st_q   <= L_SUB;
						end
						default: begin
							axis_q <= AX_X;
							st_q   <= L_IDLE;
							done_q <= 1'b1;
						end
					endcase
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (start) begin
					rem_q <= qframe - lo.frame;
					den_q <= hi.frame - lo.frame;
					t_q   <= '0;
				end
			end
			L_DIV: begin
				rem_q <= ge ? r2_sub[FRAME_W-1:0] : r2[FRAME_W-1:0];
				t_q   <= {t_q[FRAC_W-2:0], ge};
			end
			L_SUB: diff_q <= {b_sel[POS_W-1], b_sel} - {a_sel[POS_W-1], a_sel};
			L_MUL: prod_q <= diff_q * $signed({1'b0, t_q});
			L_ADD: begin
				case (axis_q)
					AX_X:    res_q.x <= sum;
					AX_Y:    res_q.y <= sum;
					default: res_q.z <= sum;
				endcase
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign pos  = res_q;

endmodule

>>> rtl/keyframe_position_lerp.sv
// keyframe position track with linear interpolation, top level
// clear and append: result via the done state and output register; query through first and
// last key checks, key scan (one key read per cycle), the 16-step divider and per-axis lerp steps
// one item at a time; a new item is taken while the previous result waits
// async reset: empty track, defaults zero, no result pending; key ram not cleared
`timescale 1ns / 1ps
`include "keyframe_position_lerp_assert.svh"

module keyframe_position_lerp import kpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [FRAME_W-1:0]      frame,
	input  logic signed [POS_W-1:0] in_x,
	input  logic signed [POS_W-1:0] in_y,
	input  logic signed [POS_W-1:0] in_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [POS_W-1:0] out_x,
	output logic signed [POS_W-1:0] out_y,
	output logic signed [POS_W-1:0] out_z,
	output logic                    status,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [POS_W-1:0]        cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CHK0 = 6'b000010,
		S_CHKL = 6'b000100,
		S_SCAN = 6'b001000,
		S_LERP = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FRAME_W-1:0] frame_q;
	key_t               lo_q;
	key_t               hi_q;
	pos_t               res_q;
	logic               res_status_q;
	pos_t               def_q;
	logic               start_q;
	logic               out_valid_q;
	pos_t               out_q;
	logic               out_status_q;

	logic             transfer;
	logic             full;
	logic             wr_en;
	key_t             wr_key;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] rd_addr;
	key_t             rd_data;
	logic             le0;
	logic             ge_last;
	logic             hit;
	logic             load_out;
	logic             lerp_done;
	pos_t             lerp_pos;

	assign in_ready = state_q == S_IDLE;
	assign transfer = in_valid && in_ready;
	assign full     = count_q == CNT_W'(MAX_KEYS);
	assign wr_en    = transfer && (action == ACT_APPEND) && !full;
	assign wr_key   = '{frame: frame, x: in_x, y: in_y, z: in_z};
	assign cnt_m1   = count_q - CNT_W'(1);
	assign le0      = frame_q <= rd_data.frame;
	assign ge_last  = frame_q >= rd_data.frame;
	assign hit      = frame_q < rd_data.frame;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		case (state_q)
			S_CHK0:  rd_addr = cnt_m1[IDX_W-1:0];
			S_CHKL:  rd_addr = IDX_W'(1);
			S_SCAN:  rd_addr = idx_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	kpl_key_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_key),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	kpl_lerp_unit u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.qframe (frame_q),
		.lo     (lo_q),
		.hi     (hi_q),
		.done   (lerp_done),
		.pos    (lerp_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			def_q       <= '0;
		end else begin
			start_q <= (state_q == S_SCAN) && hit;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEFAULT_X: def_q.x <= cfg_data;
					CFG_DEFAULT_Y: def_q.y <= cfg_data;
					CFG_DEFAULT_Z: def_q.z <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (transfer) begin
						case (action)
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							ACT_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= S_DONE;
							end
							ACT_QUERY: state_q <= (count_q == '0) ? S_DONE : S_CHK0;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_CHK0: state_q <= le0 ? S_DONE : S_CHKL;
				S_CHKL: state_q <= ge_last ? S_DONE : S_SCAN;
				S_SCAN: begin
					if (hit) begin
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					if (lerp_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (transfer) begin
					frame_q      <= frame;
					res_status_q <= (action == ACT_APPEND) && full;
					if ((action == ACT_QUERY) && (count_q == '0)) begin
						res_q <= def_q;
					end else begin
						res_q <= '0;
					end
				end
			end
			S_CHK0: begin
				lo_q <= rd_data;
				if (le0) begin
					res_q <= key_pos(rd_data);
				end
			end
			S_CHKL: begin
				idx_q <= IDX_W'(1);
				if (ge_last) begin
					res_q <= key_pos(rd_data);
				end
			end
			S_SCAN: begin
				if (hit) begin
					hi_q <= rd_data;
				end else begin
					lo_q  <= rd_data;
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_LERP: begin
				if (lerp_done) begin
					res_q <= lerp_pos;
				end
			end
			S_DONE: begin
				if (load_out) begin
					out_q        <= res_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_z     = out_q.z;
	assign status    = out_status_q;

	`KPL_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(MAX_KEYS), "key count beyond track depth")
	`KPL_ASSERT_ALWAYS(a_lerp_done_state, !lerp_done || (state_q == S_LERP), "lerp done outside lerp wait")
	`KPL_ASSERT_ALWAYS(a_scan_in_track, (state_q != S_SCAN) || ({1'b0, idx_q} <= cnt_m1), "scan past last key")
	`KPL_ASSERT_NEXT(a_append_count, wr_en, count_q == $past(count_q) + CNT_W'(1), "append did not add a key")

endmodule
